// ===== src/tpsp_pkg.sv =====
// Package for the tape pulse store: constants, transfer payload types and sequencer states.
// Used by tape_pulse_store_playback and tpsp_checker.
package tpsp_pkg;

	localparam int SLOT_CAPACITY = 65536;
	localparam int SEEK_SPACING  = 8192;
	localparam int SEEK_ENTRIES  = 8;
	localparam int TIME_BITS     = 48;
	localparam int WIDTH_BITS    = 32;
	localparam int HALF_BITS     = 16;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_READ   = 2'd2,
		OP_SEEK   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]            operation;
		logic [WIDTH_BITS-1:0] pulse_width;
		logic [TIME_BITS-1:0]  time_point;
	} in_t;

	typedef struct packed {
		logic                 level;
		logic                 failed;
		logic [TIME_BITS-1:0] tape_length;
	} out_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_APP_CHECK,
		ST_APP_WRITE,
		ST_APP_SUM,
		ST_APP_SEEK,
		ST_ADV_TEST,
		ST_ADV_DATA,
		ST_ADV_LO,
		ST_ADV_HI,
		ST_ADV_CMP,
		ST_SK_TEST,
		ST_SK_CMP,
		ST_SK_LOAD,
		ST_DONE
	} state_t;

endpackage

// ===== src/tpsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== src/tape_pulse_store_playback.sv =====
// Top level of the tape pulse store: sequencer, cursor datapath, slot RAM and seek table RAM.
// Depends on tpsp_pkg and tpsp_ram.
//
// Usage: one input channel (in_valid/in_ready/in_data) carries an operation: clear,
// append pulse, read level at a time, or seek to a time. Every transfer gives exactly
// one result on the output channel (out_valid/out_ready/out_data): cursor level,
// sticky failure flag and total tape length after the operation.
// One item is worked on at a time; in_ready is high only when the sequencer is idle
// and the output register is empty.
// Steps: clear passes the clear state; append checks room and ends there if rejected,
// else writes one slot or an escaped pulse (zero, low half, high half), adds the width
// to the length and may add a seek entry; read walks forward pulse by pulse until the
// store ends or a pulse ends after the time; seek bisects the seek table, loads the
// entry found unless it is the first (else it starts at slot zero), then walks on.
// The slot RAM has one read port, so the forward walk reads its slots one after another;
// bisection reads one seek entry per step from the seek table RAM.
// A stalled receiver holds the result in the output register and keeps in_ready low.
// Reset (arst_n low) empties the store, the seek table and the cursor at once; no
// clearing pass is needed since only written slots and entries are ever read.
module tape_pulse_store_playback #(
	parameter int SLOT_CAPACITY = tpsp_pkg::SLOT_CAPACITY,
	parameter int SEEK_SPACING  = tpsp_pkg::SEEK_SPACING,
	parameter int SEEK_ENTRIES  = tpsp_pkg::SEEK_ENTRIES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tpsp_pkg::in_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output tpsp_pkg::out_t out_data
);

	localparam int TB  = tpsp_pkg::TIME_BITS;
	localparam int WB  = tpsp_pkg::WIDTH_BITS;
	localparam int HB  = tpsp_pkg::HALF_BITS;
	localparam int CW  = $clog2(SLOT_CAPACITY + 1);
	localparam int AW  = $clog2(SLOT_CAPACITY);
	localparam int ECW = $clog2(SEEK_ENTRIES + 1);
	localparam int EAW = (SEEK_ENTRIES > 1) ? $clog2(SEEK_ENTRIES) : 1;
	localparam int EDEPTH = (SEEK_ENTRIES > 1) ? SEEK_ENTRIES : 2;
	localparam int SW  = TB + CW + 1;

	tpsp_pkg::state_t state_q, state_d;

	logic [WB-1:0] width_q;
	logic [TB-1:0] t_q;
	logic [1:0]    wr_idx_q;

	logic [CW-1:0]  slot_count_q, last_seek_q, cursor_q, next_q;
	logic [TB-1:0]  total_q, edge_q;
	logic           build_level_q, failed_q, cur_level_q;
	logic [ECW-1:0] seek_count_q, lo_q, hi_q, mid_q;
	logic [WB-1:0]  pw_q;

	logic           out_valid_q;
	tpsp_pkg::out_t out_q;

	// slot RAM port
	logic          slot_we;
	logic [AW-1:0] slot_waddr, slot_raddr;
	logic [HB-1:0] slot_wdata, slot_rdata;
	// seek table RAM port
	logic           seek_we;
	logic [EAW-1:0] seek_waddr, seek_raddr;
	logic [SW-1:0]  seek_wdata, seek_rdata;

	logic           accept;
	logic           need3;
	logic [CW:0]    avail;
	logic           no_room;
	logic [TB:0]    total_sum;
	logic [TB:0]    edge_sum;
	logic           spacing_hit;
	logic [ECW-1:0] mid;
	logic [CW-1:0]  cur_p1, cur_p2, cur_p3;
	logic [TB-1:0]  seek_time;
	logic [CW-1:0]  seek_slot;
	logic           seek_level;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == tpsp_pkg::ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign need3     = (width_q[WB-1:HB] != '0);
	assign avail     = (CW+1)'(SLOT_CAPACITY) - {1'b0, slot_count_q};
	assign no_room   = (slot_count_q > CW'(SLOT_CAPACITY)) ||
	                   ((need3 ? (CW+1)'(3) : (CW+1)'(1)) > avail);
	assign total_sum = {1'b0, total_q} + (TB+1)'(width_q);
	assign edge_sum  = {1'b0, edge_q} + (TB+1)'(pw_q);
	assign spacing_hit = (32'(slot_count_q - last_seek_q) >= 32'(SEEK_SPACING)) &&
	                     (seek_count_q < ECW'(SEEK_ENTRIES));
	assign mid       = lo_q + ((hi_q - lo_q + ECW'(1)) >> 1);
	assign cur_p1    = cursor_q + CW'(1);
	assign cur_p2    = cursor_q + CW'(2);
	assign cur_p3    = cursor_q + CW'(3);
	assign {seek_time, seek_slot, seek_level} = seek_rdata;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tpsp_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_data.operation)
						tpsp_pkg::OP_CLEAR:  state_d = tpsp_pkg::ST_CLEAR;
						tpsp_pkg::OP_APPEND: state_d = tpsp_pkg::ST_APP_CHECK;
						tpsp_pkg::OP_READ:   state_d = tpsp_pkg::ST_ADV_TEST;
						default:             state_d = tpsp_pkg::ST_SK_TEST;
					endcase
				end
			end
			tpsp_pkg::ST_CLEAR: state_d = tpsp_pkg::ST_DONE;
			tpsp_pkg::ST_APP_CHECK: begin
				if (failed_q || no_room) begin
					state_d = tpsp_pkg::ST_DONE;
				end else begin
					state_d = tpsp_pkg::ST_APP_WRITE;
				end
			end
			tpsp_pkg::ST_APP_WRITE: begin
				if (!need3 || wr_idx_q == 2'd2) begin
					state_d = tpsp_pkg::ST_APP_SUM;
				end
			end
			tpsp_pkg::ST_APP_SUM:  state_d = tpsp_pkg::ST_APP_SEEK;
			tpsp_pkg::ST_APP_SEEK: state_d = tpsp_pkg::ST_DONE;
			tpsp_pkg::ST_ADV_TEST: begin
				if (cursor_q < slot_count_q) begin
					state_d = tpsp_pkg::ST_ADV_DATA;
				end else begin
					state_d = tpsp_pkg::ST_DONE;
				end
			end
			tpsp_pkg::ST_ADV_DATA: begin
				if (slot_rdata != '0 || cur_p2 >= slot_count_q) begin
					state_d = tpsp_pkg::ST_ADV_CMP;
				end else begin
					state_d = tpsp_pkg::ST_ADV_LO;
				end
			end
			tpsp_pkg::ST_ADV_LO: state_d = tpsp_pkg::ST_ADV_HI;
			tpsp_pkg::ST_ADV_HI: state_d = tpsp_pkg::ST_ADV_CMP;
			tpsp_pkg::ST_ADV_CMP: begin
				if (edge_sum > {1'b0, t_q}) begin
					state_d = tpsp_pkg::ST_DONE;
				end else begin
					state_d = tpsp_pkg::ST_ADV_TEST;
				end
			end
			tpsp_pkg::ST_SK_TEST: begin
				if (lo_q < hi_q) begin
					state_d = tpsp_pkg::ST_SK_CMP;
				end else if (lo_q == '0) begin
					state_d = tpsp_pkg::ST_ADV_TEST;
				end else begin
					state_d = tpsp_pkg::ST_SK_LOAD;
				end
			end
			tpsp_pkg::ST_SK_CMP:  state_d = tpsp_pkg::ST_SK_TEST;
			tpsp_pkg::ST_SK_LOAD: state_d = tpsp_pkg::ST_ADV_TEST;
			tpsp_pkg::ST_DONE:    state_d = tpsp_pkg::ST_IDLE;
			default:              state_d = tpsp_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = slot_count_q[AW-1:0];
		slot_wdata = width_q[HB-1:0];
		slot_raddr = cursor_q[AW-1:0];
		seek_we    = 1'b0;
		seek_waddr = seek_count_q[EAW-1:0];
		seek_wdata = {total_q, slot_count_q, build_level_q};
		seek_raddr = mid[EAW-1:0];
		case (state_q)
			tpsp_pkg::ST_APP_WRITE: begin
				slot_we = 1'b1;
				if (need3) begin
					case (wr_idx_q)
						2'd0:    slot_wdata = '0;
						2'd1:    slot_wdata = width_q[HB-1:0];
						default: slot_wdata = width_q[WB-1:HB];
					endcase
				end
			end
			tpsp_pkg::ST_APP_SEEK: seek_we = spacing_hit;
			tpsp_pkg::ST_ADV_DATA: slot_raddr = cur_p1[AW-1:0];
			tpsp_pkg::ST_ADV_LO:   slot_raddr = cur_p2[AW-1:0];
			tpsp_pkg::ST_SK_TEST: begin
				if (!(lo_q < hi_q)) begin
					seek_raddr = lo_q[EAW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// store and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q  <= '0;
			total_q       <= '0;
			build_level_q <= 1'b0;
			seek_count_q  <= ECW'(1);
			last_seek_q   <= '0;
			failed_q      <= 1'b0;
			cursor_q      <= '0;
			edge_q        <= '0;
			cur_level_q   <= 1'b0;
			wr_idx_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tpsp_pkg::ST_IDLE: begin
					wr_idx_q <= '0;
				end
				tpsp_pkg::ST_CLEAR: begin
					slot_count_q  <= '0;
					total_q       <= '0;
					build_level_q <= 1'b0;
					seek_count_q  <= ECW'(1);
					last_seek_q   <= '0;
					failed_q      <= 1'b0;
					cursor_q      <= '0;
					edge_q        <= '0;
					cur_level_q   <= 1'b0;
				end
				tpsp_pkg::ST_APP_CHECK: begin
					if (!failed_q && no_room) begin
						failed_q <= 1'b1;
					end
				end
				tpsp_pkg::ST_APP_WRITE: begin
					slot_count_q <= slot_count_q + CW'(1);
					wr_idx_q     <= wr_idx_q + 2'd1;
				end
				tpsp_pkg::ST_APP_SUM: begin
					// saturate the length
					total_q       <= total_sum[TB] ? '1 : total_sum[TB-1:0];
					build_level_q <= !build_level_q;
				end
				tpsp_pkg::ST_APP_SEEK: begin
					if (spacing_hit) begin
						seek_count_q <= seek_count_q + ECW'(1);
						last_seek_q  <= slot_count_q;
					end
				end
				tpsp_pkg::ST_ADV_CMP: begin
					if (!(edge_sum > {1'b0, t_q})) begin
						cursor_q    <= next_q;
						edge_q      <= edge_sum[TB-1:0];
						cur_level_q <= !cur_level_q;
					end
				end
				tpsp_pkg::ST_SK_TEST: begin
					if (!(lo_q < hi_q) && lo_q == '0) begin
						cursor_q    <= '0;
						edge_q      <= '0;
						cur_level_q <= 1'b0;
					end
				end
				tpsp_pkg::ST_SK_LOAD: begin
					cursor_q    <= seek_slot;
					edge_q      <= seek_time;
					cur_level_q <= seek_level;
				end
				tpsp_pkg::ST_DONE: begin
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// item and walk payload
	always_ff @(posedge clk) begin
		if (accept) begin
			width_q <= (in_data.pulse_width == '0) ? WB'(1) : in_data.pulse_width;
			t_q     <= (in_data.time_point > total_q) ? total_q : in_data.time_point;
			lo_q    <= '0;
			hi_q    <= seek_count_q - ECW'(1);
		end
		case (state_q)
			tpsp_pkg::ST_ADV_DATA: begin
				if (slot_rdata != '0) begin
					pw_q   <= WB'(slot_rdata);
					next_q <= cur_p1;
				end else if (cur_p2 >= slot_count_q) begin
					// escape without both halves
					pw_q   <= '0;
					next_q <= slot_count_q;
				end
			end
			tpsp_pkg::ST_ADV_LO: pw_q[HB-1:0] <= slot_rdata;
			tpsp_pkg::ST_ADV_HI: begin
				pw_q[WB-1:HB] <= slot_rdata;
				next_q        <= cur_p3;
			end
			tpsp_pkg::ST_SK_TEST: mid_q <= mid;
			tpsp_pkg::ST_SK_CMP: begin
				if (seek_time <= t_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q - ECW'(1);
				end
			end
			tpsp_pkg::ST_DONE: begin
				out_q.level       <= cur_level_q;
				out_q.failed      <= failed_q;
				out_q.tape_length <= total_q;
			end
			default: begin
			end
		endcase
	end

	tpsp_ram #(
		.WIDTH(HB),
		.DEPTH(SLOT_CAPACITY)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (slot_we),
		.wr_addr(slot_waddr),
		.wr_data(slot_wdata),
		.rd_addr(slot_raddr),
		.rd_data(slot_rdata)
	);

	tpsp_ram #(
		.WIDTH(SW),
		.DEPTH(EDEPTH)
	) u_seek_ram (
		.clk    (clk),
		.wr_en  (seek_we),
		.wr_addr(seek_waddr),
		.wr_data(seek_wdata),
		.rd_addr(seek_raddr),
		.rd_data(seek_rdata)
	);

endmodule

// ===== src/tpsp_checker.sv =====
// Port-level checker for the tape pulse store, bound to the top level.
// Depends on tpsp_pkg.
module tpsp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input tpsp_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input tpsp_pkg::out_t out_data
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// one item at a time: no transfer while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while result pending");

	// busy right after an input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("ready or result too early after transfer");

	// a clear empties the store
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.operation == tpsp_pkg::OP_CLEAR |=> ##2
		out_valid && !out_data.failed && !out_data.level && out_data.tape_length == '0)
		else $error("clear result not empty");

endmodule

bind tape_pulse_store_playback tpsp_checker u_tpsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
